@@ design/sse_pkg.sv @@
// Shared constants, types and helpers for the stack set engine.
package sse_pkg;

   localparam int NUM_STACKS   = 16;
   localparam int MAX_CAPACITY = 64;
   localparam int STACK_W      = $clog2(NUM_STACKS);
   localparam int SLOT_W       = $clog2(MAX_CAPACITY);
   localparam int COUNT_W      = $clog2(MAX_CAPACITY + 1);
   localparam int ADDR_W       = STACK_W + SLOT_W;
   localparam int WORD_W       = 32;
   localparam int CAP_W        = 7;
   localparam int OP_W         = 2;
   localparam int INDEX_W      = 4;
   localparam int STATUS_W     = 2;

   localparam logic [OP_W-1:0] OP_PUSH   = 2'd0;
   localparam logic [OP_W-1:0] OP_POP    = 2'd1;
   localparam logic [OP_W-1:0] OP_POP_AT = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
   localparam logic [STATUS_W-1:0] ST_NO_STACK = 2'd3;

   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(MAX_CAPACITY);

   typedef enum logic {
      S_IDLE,
      S_FETCH
   } sse_state_type;

   typedef struct packed {
      logic              wr_en;
      logic              rd_en;
      logic [ADDR_W-1:0] addr;
      logic [WORD_W-1:0] wdata;
   } sse_mem_req_type;

   typedef struct packed {
      logic                from_mem;
      logic [STATUS_W-1:0] status;
   } sse_result_type;

   function automatic logic [COUNT_W-1:0] eff_capacity(input logic [CAP_W-1:0] cfg);
      logic [COUNT_W-1:0] cap;
      if (cfg == '0) begin
         cap = COUNT_W'(1);
      end else if (int'(cfg) > MAX_CAPACITY) begin
         cap = COUNT_W'(MAX_CAPACITY);
      end else begin
         cap = COUNT_W'(cfg);
      end
      return cap;
   endfunction

endpackage

@@ design/sse_entry_ram.sv @@
// Entry storage: single-port synchronous RAM with registered read data.
module sse_entry_ram
   import sse_pkg::*;
(
   input  logic                  clock,
   input  sse_mem_req_type       mem_req,
   output logic [WORD_W-1:0]     rd_data
);

   logic [WORD_W-1:0] entry_mem [NUM_STACKS*MAX_CAPACITY];
   logic [WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         entry_mem[mem_req.addr] <= mem_req.wdata;
      end
      if (mem_req.rd_en) begin
         rd_data_ff <= entry_mem[mem_req.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/sse_stack_ctrl.sv @@
// Stack bookkeeping: entry counts, open stack and RAM access per operation.
module sse_stack_ctrl
   import sse_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic [OP_W-1:0]      operation,
   input  logic [WORD_W-1:0]    push_value,
   input  logic [INDEX_W-1:0]   stack_index,
   input  logic [CAP_W-1:0]     capacity_cfg,
   output sse_mem_req_type      mem_req,
   output sse_result_type       result
);

   logic [COUNT_W-1:0] count_ff [NUM_STACKS];
   logic [COUNT_W-1:0] count_in [NUM_STACKS];
   logic [STACK_W-1:0] cur_ff;
   logic [STACK_W-1:0] cur_in;
   logic               cur_valid_ff;
   logic               cur_valid_in;
   sse_result_type     result_ff;
   sse_result_type     result_in;

   always_comb begin
      logic [COUNT_W-1:0] cap;
      logic               top_found;
      logic [STACK_W-1:0] top_idx;
      logic [STACK_W-1:0] new_idx;
      logic [STACK_W-1:0] sel;
      logic [COUNT_W-1:0] less_one;

      cap       = eff_capacity(capacity_cfg);
      top_found = 1'b0;
      top_idx   = '0;
      for (int i = 0; i < NUM_STACKS; i++) begin
         if (count_ff[i] != '0) begin
            top_found = 1'b1;
            top_idx   = STACK_W'(i);
         end
      end
      new_idx  = cur_valid_ff ? cur_ff + STACK_W'(1) : '0;
      sel      = stack_index[STACK_W-1:0];
      less_one = '0;

      count_in     = count_ff;
      cur_in       = cur_ff;
      cur_valid_in = cur_valid_ff;
      result_in    = result_ff;
      mem_req      = '0;
      mem_req.wdata = push_value;

      if (accept) begin
         result_in.from_mem = 1'b0;
         result_in.status   = ST_OK;
         case (operation)
            OP_PUSH: begin
               if (!cur_valid_ff || count_ff[cur_ff] >= cap) begin
                  if (cur_valid_ff && cur_ff == STACK_W'(NUM_STACKS - 1)) begin
                     result_in.status = ST_FULL;
                  end else begin
                     mem_req.wr_en     = 1'b1;
                     mem_req.addr      = {new_idx, SLOT_W'(0)};
                     count_in[new_idx] = COUNT_W'(1);
                     cur_in            = new_idx;
                     cur_valid_in      = 1'b1;
                  end
               end else begin
                  mem_req.wr_en    = 1'b1;
                  mem_req.addr     = {cur_ff, count_ff[cur_ff][SLOT_W-1:0]};
                  count_in[cur_ff] = count_ff[cur_ff] + COUNT_W'(1);
               end
            end
            OP_POP: begin
               if (!top_found) begin
                  result_in.status = ST_EMPTY;
                  cur_valid_in     = 1'b0;
               end else begin
                  less_one           = count_ff[top_idx] - COUNT_W'(1);
                  cur_in             = top_idx;
                  cur_valid_in       = 1'b1;
                  mem_req.rd_en      = 1'b1;
                  mem_req.addr       = {top_idx, less_one[SLOT_W-1:0]};
                  count_in[top_idx]  = less_one;
                  result_in.from_mem = 1'b1;
               end
            end
            OP_POP_AT: begin
               if (int'(stack_index) >= NUM_STACKS || !cur_valid_ff || sel > cur_ff) begin
                  result_in.status = ST_NO_STACK;
               end else if (count_ff[sel] == '0) begin
                  result_in.status = ST_EMPTY;
               end else begin
                  less_one           = count_ff[sel] - COUNT_W'(1);
                  mem_req.rd_en      = 1'b1;
                  mem_req.addr       = {sel, less_one[SLOT_W-1:0]};
                  count_in[sel]      = less_one;
                  result_in.from_mem = 1'b1;
               end
            end
            default: begin
               result_in.status = ST_OK;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_STACKS; i++) begin
            count_ff[i] <= '0;
         end
         cur_ff       <= '0;
         cur_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         cur_ff       <= cur_in;
         cur_valid_ff <= cur_valid_in;
      end
      result_ff <= result_in;
   end

   assign result = result_ff;

endmodule

@@ design/stack_set_engine_core.sv @@
// Top level of the stack set engine: handshakes, sequencing and output register.
//
//  channel | direction | handshake          | payload
//  req_    | in        | req_valid/req_stall | operation, push_value, stack_index
//  rsp_    | out       | rsp_valid/rsp_stall | pop_value, status
//  csr_    | in        | csr_valid/csr_ready | stack_capacity
//
// Each transfer updates counts and accesses the entry RAM, then the fetch state
// passes the registered RAM read data into the output register once it is free.
// A result held in the output register does not block the next request.
// Reset is synchronous: all stacks empty, no stack open, capacity 64.
// rsp_stall holds the output register; req_stall rises while an item is in flight.
module stack_set_engine_core
   import sse_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [OP_W-1:0]             req_operation,
   input  logic signed [WORD_W-1:0]    req_push_value,
   input  logic [INDEX_W-1:0]          req_stack_index,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic signed [WORD_W-1:0]    rsp_pop_value,
   output logic [STATUS_W-1:0]         rsp_status,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [CAP_W-1:0]            csr_stack_capacity
);

   sse_state_type       state_ff;
   sse_state_type       state_in;
   logic [CAP_W-1:0]    cap_ff;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic [WORD_W-1:0]   rsp_value_ff;
   logic [WORD_W-1:0]   rsp_value_in;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [STATUS_W-1:0] rsp_status_in;
   logic                accept;
   logic                deliver;
   sse_mem_req_type     mem_req;
   sse_result_type      result;
   logic [WORD_W-1:0]   rd_data;

   sse_stack_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .operation    (req_operation),
      .push_value   (req_push_value),
      .stack_index  (req_stack_index),
      .capacity_cfg (cap_ff),
      .mem_req      (mem_req),
      .result       (result)
   );

   sse_entry_ram u_ram (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   // advance on transfer, hold the fetch until the output register is free
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_FETCH;
            end
         end
         S_FETCH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      req_stall = 1'b1;
      deliver   = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
         end
         S_FETCH: begin
            deliver = !rsp_valid_ff || !rsp_stall;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      if (deliver) begin
         rsp_valid_in  = 1'b1;
         rsp_value_in  = result.from_mem ? rd_data : '0;
         rsp_status_in = result.status;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cap_ff       <= CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            cap_ff <= csr_stack_capacity;
         end
      end
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_pop_value = rsp_value_ff;
   assign rsp_status    = rsp_status_ff;

   a_accept_fetch: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == S_FETCH)
      else $error("accepted request did not enter fetch");

   a_rsp_from_fetch: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_FETCH))
      else $error("response raised outside fetch");

   a_mem_on_accept: assert property (@(posedge clock) disable iff (reset)
      (mem_req.rd_en || mem_req.wr_en) |-> accept)
      else $error("entry RAM accessed without a request transfer");

   a_read_means_data: assert property (@(posedge clock) disable iff (reset)
      mem_req.rd_en |=> result.from_mem && result.status == ST_OK)
      else $error("RAM read without a data result");

endmodule

@@ tb/stack_set_engine_core_tb.sv @@
// Self-checking testbench for stack_set_engine_core: shadow stack set, random traffic, stalls.
module stack_set_engine_core_tb
   import sse_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [OP_W-1:0] OP_NONE = 2'd3;

   typedef struct {
      logic signed [WORD_W-1:0] value;
      logic [STATUS_W-1:0]      status;
   } pop_result_type;

   class stack_shadow;
      logic signed [WORD_W-1:0] entries[NUM_STACKS][MAX_CAPACITY];
      int                       counts[NUM_STACKS];
      int                       top_stack;
      logic [CAP_W-1:0]         capacity;
      pop_result_type           expected_q[$];
      int                       mismatches;

      function new();
         foreach (counts[i]) counts[i] = 0;
         top_stack  = -1;
         capacity   = CAP_RESET;
         mismatches = 0;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function void apply_request(input logic [OP_W-1:0] op,
                                  input logic signed [WORD_W-1:0] word,
                                  input logic [INDEX_W-1:0] idx);
         pop_result_type r;
         int             cap;
         r.value  = '0;
         r.status = ST_OK;
         cap = (capacity == '0) ? 1 :
               (int'(capacity) > MAX_CAPACITY) ? MAX_CAPACITY : int'(capacity);
         case (op)
            OP_PUSH: begin
               if (top_stack < 0 || counts[top_stack] >= cap) begin
                  if (top_stack + 1 >= NUM_STACKS) begin
                     r.status = ST_FULL;
                  end else begin
                     top_stack++;
                     entries[top_stack][0] = word;
                     counts[top_stack]     = 1;
                  end
               end else begin
                  entries[top_stack][counts[top_stack]] = word;
                  counts[top_stack]++;
               end
            end
            OP_POP: begin
               while (top_stack >= 0 && counts[top_stack] == 0) top_stack--;
               if (top_stack < 0) begin
                  r.status = ST_EMPTY;
               end else begin
                  counts[top_stack]--;
                  r.value = entries[top_stack][counts[top_stack]];
               end
            end
            OP_POP_AT: begin
               if (top_stack < 0 || int'(idx) > top_stack) begin
                  r.status = ST_NO_STACK;
               end else if (counts[idx] == 0) begin
                  r.status = ST_EMPTY;
               end else begin
                  counts[idx]--;
                  r.value = entries[idx][counts[idx]];
               end
            end
            default: ;
         endcase
         expected_q.push_back(r);
      endfunction

      task report(input string msg);
         if (mismatches < 100) $display("%0t ns: %s", $realtime, msg);
         mismatches++;
      endtask

      task check_response(input logic signed [WORD_W-1:0] value,
                          input logic [STATUS_W-1:0] status);
         pop_result_type want;
         if (expected_q.size() == 0) begin
            report($sformatf("unexpected result value %0d status %0d", value, status));
         end else begin
            want = expected_q.pop_front();
            if (value !== want.value)
               report($sformatf("pop_value %0d, want %0d", value, want.value));
            if (status !== want.status)
               report($sformatf("status %0d, want %0d", status, want.status));
         end
      endtask
   endclass

   logic                     clock;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic [OP_W-1:0]          req_operation = '0;
   logic signed [WORD_W-1:0] req_push_value = '0;
   logic [INDEX_W-1:0]       req_stack_index = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic signed [WORD_W-1:0] rsp_pop_value;
   logic [STATUS_W-1:0]      rsp_status;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CAP_W-1:0]         csr_stack_capacity = '0;

   bit          quiet = 1'b0;
   stack_shadow book = new();

   stack_set_engine_core i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_operation      (req_operation),
      .req_push_value     (req_push_value),
      .req_stack_index    (req_stack_index),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_pop_value      (rsp_pop_value),
      .rsp_status         (rsp_status),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_stack_capacity (csr_stack_capacity)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(negedge clock) begin
      rsp_stall <= !quiet && ($urandom_range(0, 99) < 11);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) book.check_response(rsp_pop_value, rsp_status);
   end

   task automatic send_request(input logic [OP_W-1:0] op,
                               input logic signed [WORD_W-1:0] word,
                               input logic [INDEX_W-1:0] idx);
      while (!quiet && $urandom_range(0, 99) < 11) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_operation   <= op;
      req_push_value  <= word;
      req_stack_index <= idx;
      do @(posedge clock); while (req_stall);
      book.apply_request(op, word, idx);
      @(negedge clock);
   endtask

   task automatic write_capacity(input logic [CAP_W-1:0] cap);
      req_valid <= 1'b0;
      while (book.pending() != 0) @(negedge clock);
      csr_valid          <= 1'b1;
      csr_stack_capacity <= cap;
      do @(posedge clock); while (!csr_ready);
      book.capacity = cap;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic random_request(input int push_bias);
      logic [OP_W-1:0]    op;
      logic [INDEX_W-1:0] idx;
      int                 pick;
      pick = $urandom_range(0, 9);
      if ($urandom_range(0, 99) < push_bias) op = OP_PUSH;
      else if (pick < 5) op = OP_POP;
      else if (pick < 9) op = OP_POP_AT;
      else op = OP_NONE;
      idx = INDEX_W'($urandom);
      if (op == OP_POP_AT && book.top_stack >= 0 && $urandom_range(0, 3) != 0)
         idx = INDEX_W'($urandom_range(0, book.top_stack));
      send_request(op, $urandom, idx);
   endtask

   initial begin
      logic [CAP_W-1:0] capacity_plan[10] = '{7'd127, 7'd2, 7'd64, 7'd1, 7'd3,
                                              7'd65, 7'd0, 7'd5, 7'd100, 7'd7};
      int               push_bias[10] = '{80, 40, 70, 50, 60, 35, 75, 45, 65, 50};
      logic signed [WORD_W-1:0] edge_words[7] = '{32'sh8000_0000, 32'sh7fff_ffff, 32'sh0,
                                                  -32'sd1, 32'sd1, 32'sh5555_5555,
                                                  32'shaaaa_aaaa};

      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // capacity zero acts as one: every push opens a new stack until none is left
      write_capacity(7'd0);
      send_request(OP_POP, 32'sd5, 4'd0);
      send_request(OP_POP_AT, -32'sd1, 4'd0);
      send_request(OP_NONE, 32'sh1234_5678, 4'd15);
      for (int i = 0; i < NUM_STACKS; i++)
         send_request(OP_PUSH, (i < 7) ? edge_words[i] : $urandom, 4'(i));
      send_request(OP_PUSH, 32'sd99, 4'd0);
      send_request(OP_POP_AT, 32'sd0, 4'd15);
      send_request(OP_POP_AT, 32'sd0, 4'd15);
      send_request(OP_POP, 32'sd0, 4'd0);
      send_request(OP_POP_AT, 32'sd0, 4'd15);
      send_request(OP_POP_AT, 32'sd7, 4'd3);

      for (int p = 0; p < 10; p++) begin
         write_capacity(capacity_plan[p]);
         quiet = (p == 2 || p == 3);
         for (int n = 0; n < 153; n++) random_request(push_bias[p]);
      end
      quiet = 1'b0;
      req_valid <= 1'b0;

      while (book.pending() != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      if (book.mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
